@@ rtl/lpq_pkg.sv @@
// ----------------------------------------------------------------------------
// lpq_pkg
// Types and constants shared by the linear priority queue: field widths,
// operation and status codes, item structs and the cell command bundle.
// ----------------------------------------------------------------------------
package lpq_pkg;

    localparam int unsigned DEPTH   = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned IDX_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned CAP_W   = 5;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned STAT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int unsigned      CAP_MIN   = 2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [VALUE_W-1:0]        item_value;
        logic signed [PRIO_W-1:0]  item_prio;
    } lpq_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [IDX_W-1:0]          popped_index;
        logic [VALUE_W-1:0]        popped_value;
        logic signed [PRIO_W-1:0]  popped_priority;
        logic [CNT_W-1:0]          occupancy;
        logic [IDX_W-1:0]          highest_position;
        logic [IDX_W-1:0]          lowest_position;
    } lpq_out_t;

    // Running extremes handed from cell to cell
    typedef struct packed {
        logic                      have;
        logic signed [PRIO_W-1:0]  max_pri;
        logic [IDX_W-1:0]          max_pos;
        logic [VALUE_W-1:0]        max_val;
        logic signed [PRIO_W-1:0]  min_pri;
        logic [IDX_W-1:0]          min_pos;
    } lpq_scan_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                      wr_en;
        logic [IDX_W-1:0]          wr_pos;
        logic [VALUE_W-1:0]        wr_value;
        logic signed [PRIO_W-1:0]  wr_prio;
        logic                      shift_en;
        logic [IDX_W-1:0]          shift_pos;
        logic [CNT_W-1:0]          count;
    } lpq_cmd_t;

endpackage

@@ rtl/lpq_cell.sv @@
// ----------------------------------------------------------------------------
// lpq_cell
// One queue slot: holds a value and priority, loads on push or takes its
// upper neighbor's entry on a pop shift, and folds itself into the scan.
// ----------------------------------------------------------------------------
module lpq_cell #(
    parameter int unsigned POS = 0
) (
    input  logic                             clk,
    input  lpq_pkg::lpq_cmd_t                cmd,
    input  logic [lpq_pkg::VALUE_W-1:0]      up_value,
    input  logic signed [lpq_pkg::PRIO_W-1:0] up_prio,
    input  lpq_pkg::lpq_scan_t               scan_in,
    output logic [lpq_pkg::VALUE_W-1:0]      value,
    output logic signed [lpq_pkg::PRIO_W-1:0] prio,
    output lpq_pkg::lpq_scan_t               scan_out
);
    import lpq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(POS);

    logic [VALUE_W-1:0]        value_reg;
    logic signed [PRIO_W-1:0]  prio_reg;
    lpq_scan_t                 scan_reg;
    lpq_scan_t                 scan_next;
    logic                      active;

    assign active = (MY_CNT < cmd.count);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (cmd.wr_pos == MY_IDX))
        begin
            value_reg <= cmd.wr_value;
            prio_reg  <= cmd.wr_prio;
        end
        else if (cmd.shift_en && (MY_IDX >= cmd.shift_pos))
        begin
            value_reg <= up_value;
            prio_reg  <= up_prio;
        end
    end

    // Max keeps the first hit, min keeps the last
    always_comb
    begin
        scan_next = scan_in;
        if (active)
        begin
            if (!scan_in.have || ($signed(prio_reg) > $signed(scan_in.max_pri)))
            begin
                scan_next.max_pri = prio_reg;
                scan_next.max_pos = MY_IDX;
                scan_next.max_val = value_reg;
            end
            if (!scan_in.have || ($signed(prio_reg) <= $signed(scan_in.min_pri)))
            begin
                scan_next.min_pri = prio_reg;
                scan_next.min_pos = MY_IDX;
            end
            scan_next.have = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign value    = value_reg;
    assign prio     = prio_reg;
    assign scan_out = scan_reg;

endmodule

@@ rtl/lpq_chain.sv @@
// ----------------------------------------------------------------------------
// lpq_chain
// Row of DEPTH cells. Entries shift toward position 0 on a pop; the scan
// wave enters at cell 0 and leaves at the last cell, one cell per cycle.
// ----------------------------------------------------------------------------
module lpq_chain (
    input  logic                 clk,
    input  lpq_pkg::lpq_cmd_t    cmd,
    output lpq_pkg::lpq_scan_t   scan_tail
);
    import lpq_pkg::*;

    logic [VALUE_W-1:0]        cell_value [DEPTH];
    logic signed [PRIO_W-1:0]  cell_prio  [DEPTH];
    lpq_scan_t                 cell_scan  [DEPTH];
    lpq_scan_t                 seed;

    assign seed = '0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_W-1:0]        up_value;
            logic signed [PRIO_W-1:0]  up_prio;
            lpq_scan_t                 scan_in;

            if (i == DEPTH - 1)
            begin : g_last
                assign up_value = cell_value[i];
                assign up_prio  = cell_prio[i];
            end
            else
            begin : g_mid
                assign up_value = cell_value[i+1];
                assign up_prio  = cell_prio[i+1];
            end

            if (i == 0)
            begin : g_head
                assign scan_in = seed;
            end
            else
            begin : g_body
                assign scan_in = cell_scan[i-1];
            end

            lpq_cell #(
                .POS (i)
            ) u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .up_value (up_value),
                .up_prio  (up_prio),
                .scan_in  (scan_in),
                .value    (cell_value[i]),
                .prio     (cell_prio[i]),
                .scan_out (cell_scan[i])
            );
        end
    endgenerate

    assign scan_tail = cell_scan[DEPTH-1];

endmodule

@@ rtl/linear_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// linear_priority_queue_top
// Unsorted priority queue of up to 16 entries held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. kind selects push, pop of the highest priority, or clear.
//   Result channel: result is valid for exactly one cycle while done is high;
//   it carries status, the popped entry, occupancy and the first highest and
//   last lowest priority positions after the operation.
//   Timing: the report comes from a scan wave that walks the 16 cells, one
//   cell per cycle. For push, clear, an empty pop and other kinds a single
//   scan runs after the accept edge, then a finish step registers done and
//   the result. A pop of a nonempty queue runs one scan to find the entry,
//   a shift step, then a second scan and the finish step.
//   busy drops in the done cycle, so a new item may be taken there.
//   The receiver has no back pressure; the result is shown once.
//   Configuration: APB register 0 (byte address 0) is capacity, reset 16,
//   clamped to 2..16. Write it only while the queue is not busy.
//   Reset: rst_n clears the occupancy and control and sets capacity to 16;
//   cell contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
module linear_priority_queue_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lpq_pkg::lpq_in_t    request,
    output logic                busy,
    output logic                done,
    output lpq_pkg::lpq_out_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lpq_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_POP = 3'd1;
    localparam logic [2:0] ST_POP      = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_FIN      = 3'd4;

    localparam logic [1:0]       ADDR_CAPACITY = 2'd0;
    localparam logic [IDX_W-1:0] SCAN_LAST     = IDX_W'(DEPTH - 1);

    logic [2:0]                state_reg,  state_next;
    logic [IDX_W-1:0]          cnt_reg,    cnt_next;
    logic [CNT_W-1:0]          count_reg,  count_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic [IDX_W-1:0]          pidx_reg,   pidx_next;
    logic [VALUE_W-1:0]        pval_reg,   pval_next;
    logic signed [PRIO_W-1:0]  ppri_reg,   ppri_next;
    lpq_out_t                  result_reg, result_next;
    logic                      done_reg,   done_next;
    logic [CAP_W-1:0]          capacity_reg;

    logic [CNT_W-1:0]          eff_cap;
    logic                      full;
    logic                      accept;
    logic                      cfg_write;
    lpq_cmd_t                  cmd;
    lpq_scan_t                 scan_tail;

    // Capacity clamped to 2..DEPTH
    always_comb
    begin
        if (int'(capacity_reg) < CAP_MIN)
        begin
            eff_cap = CNT_W'(CAP_MIN);
        end
        else if (int'(capacity_reg) > DEPTH)
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_reg);
        end
    end

    assign full   = (count_reg >= eff_cap);
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.wr_en     = accept && (request.kind == KIND_PUSH) && !full;
        cmd.wr_pos    = count_reg[IDX_W-1:0];
        cmd.wr_value  = request.item_value;
        cmd.wr_prio   = request.item_prio;
        cmd.shift_en  = (state_reg == ST_POP);
        cmd.shift_pos = scan_tail.max_pos;
        cmd.count     = count_reg;
    end

    lpq_chain u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .scan_tail (scan_tail)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pidx_next   = pidx_reg;
        pval_next   = pval_reg;
        ppri_next   = ppri_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    status_next = STAT_DONE;
                    pidx_next   = '0;
                    pval_next   = '0;
                    ppri_next   = '0;
                    cnt_next    = '0;
                    state_next  = ST_SCAN;
                    case (request.kind)
                        KIND_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SCAN_POP;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN_POP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                // Cells shift this cycle; take the popped entry from the scan
                pidx_next  = scan_tail.max_pos;
                pval_next  = scan_tail.max_val;
                ppri_next  = scan_tail.max_pri;
                count_next = count_reg - 1'b1;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                result_next.status           = status_reg;
                result_next.popped_index     = pidx_reg;
                result_next.popped_value     = pval_reg;
                result_next.popped_priority  = ppri_reg;
                result_next.occupancy        = count_reg;
                result_next.highest_position = scan_tail.max_pos;
                result_next.lowest_position  = scan_tail.min_pos;
                done_next                    = 1'b1;
                state_next                   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pidx_reg   <= pidx_next;
        pval_reg   <= pval_next;
        ppri_reg   <= ppri_next;
        result_reg <= result_next;
    end

    // Configuration port
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write && (paddr == ADDR_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity_reg} : 32'd0;
    assign pready = 1'b1;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/lpq_checker.sv @@
// ----------------------------------------------------------------------------
// lpq_port_checks
// Port-level checks on the command and result channels of the queue,
// attached to the top level by a bind.
// ----------------------------------------------------------------------------
module lpq_port_checks (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  lpq_pkg::lpq_out_t   result
);
    import lpq_pkg::*;

    // An accepted item holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // Result strobe only comes back once the block is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // One result per item, one cycle wide
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // An empty pop leaves an empty queue
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == STAT_EMPTY) |-> (result.occupancy == '0))
        else $error("empty status with nonzero occupancy");

    // Empty queue reports position zero for both extremes
    a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.occupancy == '0) |->
            (result.highest_position == '0) && (result.lowest_position == '0))
        else $error("empty queue reports nonzero positions");

endmodule

bind linear_priority_queue_top lpq_port_checks u_lpq_port_checks (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
